// ----- hdl/pcm_declick_ramp_top_macros.svh -----
// Assertion macros for the pcm_declick_ramp checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef PCM_DECLICK_RAMP_TOP_MACROS_SVH
`define PCM_DECLICK_RAMP_TOP_MACROS_SVH

// same-cycle implication
`define PDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pdr_pkg.sv -----
// Shared types and constants for the PCM declick ramp block.
// No dependencies.
`default_nettype none

package pdr_pkg;

  localparam int DIV_W     = 32;
  localparam int DEN_W     = 16;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SMP_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int RATE_W    = 17;
  localparam int LEN_W     = 16;

  localparam logic [RATE_W-1:0] DEFAULT_RATE = 17'd16000;
  localparam logic [DIV_W-1:0]  MS_PER_S     = 32'd1000;
  localparam logic [DIV_W-1:0]  ROUND_UP     = 32'd999;
  localparam logic [LEN_W-1:0]  MIN_TAIL     = 16'd2;

  localparam logic [DIV_W-1:0] SAT_POS_MAG = 32'd32767;
  localparam logic [DIV_W-1:0] SAT_NEG_MAG = 32'd32768;
  localparam logic [SMP_W-1:0] SAT_POS     = 16'h7FFF;
  localparam logic [SMP_W-1:0] SAT_NEG     = 16'h8000;

  localparam logic [1:0] KIND_STREAM = 2'd0;
  localparam logic [1:0] KIND_RAMP   = 2'd1;
  localparam logic [1:0] KIND_GUARD  = 2'd2;

  typedef enum logic [1:0] {OP_START, OP_BYTE, OP_FINISH, OP_TICK} op_t;
  typedef enum logic [1:0] {PH_IDLE, PH_RAMP, PH_GUARD} phase_t;
  typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_FADE_LD, ST_DIV, ST_WB} state_t;
  typedef enum logic [1:0] {SRC_START, SRC_GUARD, SRC_FADE} div_src_t;

  typedef struct packed {
    logic     take;
    logic     mul;
    logic     div_go;
    div_src_t src;
    logic     commit;
    logic     emit;
  } pdr_cmd_t;

  typedef struct packed {
    op_t  op;
    logic fade_need;
    logic out_enabled;
    logic produce;
    logic out_free;
    logic div_busy;
  } pdr_stat_t;

endpackage

`default_nettype wire

// ----- hdl/pdr_div.sv -----
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on pdr_pkg.
`default_nettype none

module pdr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [pdr_pkg::DIV_W-1:0]  dividend,
  input  logic [pdr_pkg::DEN_W-1:0]  divisor,
  output logic                       busy,
  output logic [pdr_pkg::DIV_W-1:0]  quotient
);
  import pdr_pkg::*;

  logic [DIV_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   t1, t2;
  logic [DEN_W-1:0] r1, r2;
  logic             q1, q2;

  always_comb begin
    t1 = {rem, quo[DIV_W-1]};
    q1 = (t1 >= {1'b0, den});
    r1 = q1 ? DEN_W'(t1 - {1'b0, den}) : t1[DEN_W-1:0];
    t2 = {r1, quo[DIV_W-2]};
    q2 = (t2 >= {1'b0, den});
    r2 = q2 ? DEN_W'(t2 - {1'b0, den}) : t2[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-3:0], q1, q2};
      rem <= r2;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- hdl/pdr_dpath.sv -----
// Datapath: stream and tail state, fade multiplier, shared divider, output register.
// Depends on pdr_pkg and pdr_div.
`default_nettype none

module pdr_dpath #(
  parameter int DECLICK_MS = 5,
  parameter int GUARD_MS   = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pdr_pkg::pdr_cmd_t            cmd,
  output pdr_pkg::pdr_stat_t           stat,
  input  logic [1:0]                   in_op,
  input  logic [pdr_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_end,
  input  logic                         cfg_valid,
  input  logic [pdr_pkg::RATE_W-1:0]   cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [pdr_pkg::SMP_W-1:0]    out_sample,
  output logic [1:0]                   out_kind,
  output logic                         out_last
);
  import pdr_pkg::*;

  localparam logic [DIV_W-1:0] DECLICK_K = DIV_W'(DECLICK_MS);
  localparam logic [DIV_W-1:0] GUARD_K   = DIV_W'(GUARD_MS);

  logic [RATE_W-1:0] rate, rate_next;
  op_t               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic              end_q;

  logic              streaming, streaming_next;
  logic              out_en, out_en_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  logic [LEN_W-1:0]  ramp_total, ramp_total_next;
  logic [LEN_W-1:0]  ramp_left, ramp_left_next;
  logic [SMP_W-1:0]  last_sample, last_sample_next;
  logic              last_valid, last_valid_next;
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  tail_index, tail_index_next;
  logic [LEN_W-1:0]  guard_left, guard_left_next;
  logic [RATE_W-1:0] stream_rate, stream_rate_next;

  logic [DIV_W-1:0]  prod;
  logic              neg_q;

  logic [RATE_W-1:0] r_eff;
  logic [SMP_W-1:0]  byte_sample;
  logic [LEN_W-1:0]  n_tail, tail_den;
  logic              byte_fade, tick_fade, fade_need, produce;
  logic [SMP_W-1:0]  fsrc, s_abs;
  logic [LEN_W-1:0]  fnum, fden;
  logic [DIV_W-1:0]  div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic              div_busy;
  logic [DIV_W-1:0]  quotient;
  logic [SMP_W-1:0]  faded, s_byte, s_tick;
  logic [LEN_W:0]    idx_inc;
  phase_t            ph;
  logic [LEN_W-1:0]  gl;
  logic [SMP_W-1:0]  res_sample;
  logic [1:0]        res_kind;
  logic              res_last;

  assign r_eff       = (rate == '0) ? DEFAULT_RATE : rate;
  assign byte_sample = {byte_q, held_byte};
  assign n_tail      = (ramp_total < MIN_TAIL) ? MIN_TAIL : ramp_total;
  assign tail_den    = n_tail - 1'b1;
  assign byte_fade   = (op_q == OP_BYTE) && streaming && held_valid && (ramp_left > 16'd1);
  assign tick_fade   = (op_q == OP_TICK) && (phase == PH_RAMP) && (tail_index != '0);
  assign fade_need   = byte_fade || tick_fade;
  assign produce     = ((op_q == OP_BYTE) && streaming && held_valid) ||
                       ((op_q == OP_TICK) && (phase != PH_IDLE));

  assign fsrc  = (op_q == OP_TICK) ? last_sample : byte_sample;
  assign fnum  = (op_q == OP_TICK) ? (tail_den - tail_index)
                                   : (ramp_total - ramp_left + 16'd1);
  assign fden  = (op_q == OP_TICK) ? tail_den : ramp_total;
  assign s_abs = fsrc[SMP_W-1] ? (~fsrc + 16'd1) : fsrc;

  always_comb begin
    div_divisor = MS_PER_S[DEN_W-1:0];
    case (cmd.src)
      SRC_START: div_dividend = DIV_W'(r_eff) * DECLICK_K;
      SRC_GUARD: div_dividend = DIV_W'(stream_rate) * GUARD_K + ROUND_UP;
      SRC_FADE: begin
        div_dividend = prod + DIV_W'(fden >> 1);
        div_divisor  = fden;
      end
      default: div_dividend = prod;
    endcase
  end

  pdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // rounded magnitude back to signed, saturated
  always_comb begin
    if (neg_q) begin
      faded = (quotient > SAT_NEG_MAG) ? SAT_NEG : (~quotient[SMP_W-1:0] + 16'd1);
    end else begin
      faded = (quotient > SAT_POS_MAG) ? SAT_POS : quotient[SMP_W-1:0];
    end
  end

  assign s_byte = fade_need ? faded : byte_sample;
  assign s_tick = fade_need ? faded : last_sample;

  always_comb begin
    streaming_next   = streaming;
    out_en_next      = out_en;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    ramp_total_next  = ramp_total;
    ramp_left_next   = ramp_left;
    last_sample_next = last_sample;
    last_valid_next  = last_valid;
    phase_next       = phase;
    tail_index_next  = tail_index;
    guard_left_next  = guard_left;
    stream_rate_next = stream_rate;
    rate_next        = cfg_valid ? cfg_data : rate;
    idx_inc          = {1'b0, tail_index} + 17'd1;
    ph               = phase;
    gl               = (guard_left != '0) ? (guard_left - 1'b1) : '0;
    res_sample       = '0;
    res_kind         = KIND_STREAM;
    res_last         = 1'b0;
    if (cmd.commit) begin
      case (op_q)
        OP_START: begin
          streaming_next   = 1'b1;
          out_en_next      = 1'b1;
          held_valid_next  = 1'b0;
          ramp_total_next  = (quotient == '0) ? 16'd1 : quotient[LEN_W-1:0];
          ramp_left_next   = (quotient == '0) ? 16'd1 : quotient[LEN_W-1:0];
          last_valid_next  = 1'b0;
          phase_next       = PH_IDLE;
          tail_index_next  = '0;
          guard_left_next  = '0;
          stream_rate_next = r_eff;
        end
        OP_BYTE: begin
          if (streaming) begin
            if (held_valid) begin
              held_valid_next = 1'b0;
              if (ramp_left != '0 && ramp_total != '0) begin
                ramp_left_next = ramp_left - 1'b1;
              end
              last_sample_next = s_byte;
              last_valid_next  = 1'b1;
              res_sample       = s_byte;
              res_kind         = KIND_STREAM;
            end else begin
              held_byte_next  = byte_q;
              held_valid_next = !end_q;
            end
          end
        end
        OP_FINISH: begin
          held_valid_next = 1'b0;
          if (out_en) begin
            guard_left_next = (quotient == '0) ? 16'd1 : quotient[LEN_W-1:0];
            tail_index_next = '0;
            phase_next = (last_valid && last_sample != '0) ? PH_RAMP : PH_GUARD;
          end
          streaming_next  = 1'b0;
          out_en_next     = 1'b0;
          last_valid_next = 1'b0;
          ramp_left_next  = '0;
        end
        OP_TICK: begin
          case (phase)
            PH_RAMP: begin
              tail_index_next = idx_inc[LEN_W-1:0];
              if (idx_inc >= {1'b0, n_tail}) begin
                ph = (guard_left != '0) ? PH_GUARD : PH_IDLE;
              end
              phase_next = ph;
              res_sample = s_tick;
              res_kind   = KIND_RAMP;
              res_last   = (ph == PH_IDLE);
            end
            PH_GUARD: begin
              guard_left_next = gl;
              if (gl == '0) begin
                phase_next = PH_IDLE;
              end
              res_sample = '0;
              res_kind   = KIND_GUARD;
              res_last   = (gl == '0);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate        <= DEFAULT_RATE;
      op_q        <= OP_START;
      streaming   <= 1'b0;
      out_en      <= 1'b0;
      held_valid  <= 1'b0;
      ramp_total  <= '0;
      ramp_left   <= '0;
      last_valid  <= 1'b0;
      phase       <= PH_IDLE;
      tail_index  <= '0;
      guard_left  <= '0;
      stream_rate <= '0;
      out_valid   <= 1'b0;
    end else begin
      rate        <= rate_next;
      if (cmd.take) begin
        op_q <= op_t'(in_op);
      end
      streaming   <= streaming_next;
      out_en      <= out_en_next;
      held_valid  <= held_valid_next;
      ramp_total  <= ramp_total_next;
      ramp_left   <= ramp_left_next;
      last_valid  <= last_valid_next;
      phase       <= phase_next;
      tail_index  <= tail_index_next;
      guard_left  <= guard_left_next;
      stream_rate <= stream_rate_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q <= in_byte;
      end_q  <= in_end;
    end
    held_byte   <= held_byte_next;
    last_sample <= last_sample_next;
    if (cmd.mul) begin
      prod  <= DIV_W'(s_abs) * DIV_W'(fnum);
      neg_q <= fsrc[SMP_W-1];
    end
    if (cmd.emit) begin
      out_sample <= res_sample;
      out_kind   <= res_kind;
      out_last   <= res_last;
    end
  end

  assign stat.op          = op_q;
  assign stat.fade_need   = fade_need;
  assign stat.out_enabled = out_en;
  assign stat.produce     = produce;
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.div_busy    = div_busy;

endmodule

`default_nettype wire

// ----- hdl/pdr_ctrl.sv -----
// Controller: sequences accept, fade multiply, divide and write-back per word.
// Depends on pdr_pkg.
`default_nettype none

module pdr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdr_pkg::pdr_stat_t stat,
  output pdr_pkg::pdr_cmd_t  cmd
);
  import pdr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          OP_START: begin
            cmd.div_go = 1'b1;
            cmd.src    = SRC_START;
            state_next = ST_DIV;
          end
          OP_FINISH: begin
            if (stat.out_enabled) begin
              cmd.div_go = 1'b1;
              cmd.src    = SRC_GUARD;
              state_next = ST_DIV;
            end else begin
              state_next = ST_WB;
            end
          end
          default: begin
            if (stat.fade_need) begin
              cmd.mul    = 1'b1;
              state_next = ST_FADE_LD;
            end else begin
              state_next = ST_WB;
            end
          end
        endcase
      end
      ST_FADE_LD: begin
        cmd.div_go = 1'b1;
        cmd.src    = SRC_FADE;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (!stat.produce || stat.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = stat.produce;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pcm_declick_ramp_top.sv -----
// Top level of the PCM declick ramp block.
// Depends on pdr_pkg, pdr_ctrl, pdr_dpath (and pdr_div below it).
//
// Input stream s_axis: tuser is the op (start, byte, finish, tick), tdata the
// PCM byte, tlast marks the end of a message. Output stream m_axis: tdata is
// the signed sample, tuser its kind (stream, ramp, guard), tlast the final
// word of a tail. cfg_* writes the sample rate; cfg_ready is always high.
// One input word at a time. Words with no division go from accept through
// decode to write-back; start and enabled finish words run the shared
// divider (2 quotient bits per cycle) between decode and write-back, and
// faded samples pass a fade-load state before the divider. s_axis_tready
// returns the cycle after write-back, so a new word is accepted only once
// the previous one has been written back.
// A result sits in the output register until taken; a new input word is
// accepted meanwhile, and its write-back waits only if it has a result and
// the register is still full.
// Reset clears all stream and tail state and sets the rate to 16000 Hz.
`default_nettype none

module pcm_declick_ramp_top #(
  parameter int DECLICK_MS = 5,
  parameter int GUARD_MS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);
  import pdr_pkg::*;

  pdr_cmd_t  cmd;
  pdr_stat_t stat;

  assign cfg_ready = 1'b1;

  pdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdr_dpath #(
    .DECLICK_MS (DECLICK_MS),
    .GUARD_MS   (GUARD_MS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_sample (m_axis_tdata),
    .out_kind   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/pdr_checker.sv -----
// Port-level checks for pcm_declick_ramp_top, bound onto the top level.
// Depends on pdr_pkg and pcm_declick_ramp_top_macros.svh.
`default_nettype none
`include "pcm_declick_ramp_top_macros.svh"

module pdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import pdr_pkg::*;

  `PDR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
  `PDR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `PDR_ASSERT_NOW(a_last_on_tail, m_axis_tvalid && m_axis_tlast, m_axis_tuser != KIND_STREAM, "tlast on a stream word")
  `PDR_ASSERT_NOW(a_guard_silent, m_axis_tvalid && m_axis_tuser == KIND_GUARD, m_axis_tdata == 16'd0, "guard word not silent")

endmodule

bind pcm_declick_ramp_top pdr_checker u_pdr_checker (.*);

`default_nettype wire
